// ===== rtl/ffa_pkg.sv =====
`default_nettype none

package ffa_pkg;

    localparam int FREE_ENTRIES_DEF = 16;
    localparam int ADDR_BITS_DEF    = 32;

    localparam int DATA_W    = 32;
    localparam int MINB_W    = 9;
    localparam int ALIGN_W   = 4;
    localparam int AMASK_W   = 15;
    localparam int SUM_W     = 49;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] ARENA_BASE_RST = 32'd0;
    localparam logic [DATA_W-1:0] ARENA_CAP_RST  = 32'd65536;
    localparam logic [MINB_W-1:0] MIN_BLOCK_RST  = 9'd16;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARENA_BASE,
        CFG_ARENA_CAP,
        CFG_MIN_BLOCK
    } cfg_idx_t;

    typedef enum logic [2:0] {
        STAT_REUSED,
        STAT_BUMPED,
        STAT_IGNORED,
        STAT_NO_SPACE,
        STAT_TABLE_FULL
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PICK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic              push;
        entry_t            new_entry;
        logic [DATA_W-1:0] req_size;
        logic [AMASK_W-1:0] amask;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/first_fit_free_list_allocator.sv =====
`default_nettype none

// First-fit allocator over a LIFO table of freed blocks plus a bump arena.
// Request channel: kind, req_size, align_log2 and block_addr are taken at a
// rising edge with start high and busy low. Each request gives one result
// word: done is high for exactly one cycle with result_addr and status.
// The receiver cannot stall, so nothing waits on the result side.
// done is registered from the table update step; busy drops in the same
// cycle as done rises, so a new request can be taken while done is high, but
// not before the last one is through. The four steps are: latch, per-cell
// match, priority pick of the newest hit plus bump fit check, then table update.
// The free table is a row of FREE_ENTRIES cells, newest entry in cell 0;
// a push shifts the row down, a removal shifts the cells above the hit up.
// Configuration: cfg_valid/cfg_ready write arena_base (0), arena_capacity
// (1) or min_block (2); cfg_ready is always high, other indexes are dropped.
// Writes belong in idle time only. Reset empties the table, clears the bump
// offset and loads base 0, capacity 65536, min_block 16.
module first_fit_free_list_allocator
    import ffa_pkg::*;
#(
    parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  logic [DATA_W-1:0]    req_size,
    input  logic [ALIGN_W-1:0]   align_log2,
    input  logic [DATA_W-1:0]    block_addr,

    output logic                 done,
    output logic [DATA_W-1:0]    result_addr,
    output logic [2:0]           status,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
    localparam logic [SUM_W-1:0] ADDR_MASK = (SUM_W'(1) << ADDR_BITS) - SUM_W'(1);

    state_t state_reg, state_next;

    logic [DATA_W-1:0]  base_reg, cap_reg;
    logic [MINB_W-1:0]  minb_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DATA_W-1:0]  offset_reg, offset_next;
    logic               done_reg;
    logic [DATA_W-1:0]  result_addr_reg;
    status_t            status_reg;

    logic               kind_reg;
    logic [DATA_W-1:0]  size_reg, size_in;
    logic [AMASK_W-1:0] amask_reg, amask_in;
    logic [DATA_W-1:0]  addr_reg;

    logic [FREE_ENTRIES-1:0] match_vec;
    logic [FREE_ENTRIES-1:0] occupied;
    logic [FREE_ENTRIES-1:0] pull_sel;
    logic [FREE_ENTRIES-1:0] hit_reg, hit_next;
    logic                    found_reg;
    entry_t                  entries [FREE_ENTRIES];
    cell_ctl_t               ctl;

    logic [DATA_W:0]    aligned_reg, aligned_next;
    logic               fit_reg;
    logic [DATA_W+1:0]  bump_sum;
    logic [DATA_W-1:0]  bump_end_reg;
    logic [SUM_W-1:0]   arena_sum;
    logic [DATA_W-1:0]  arena_addr_reg;
    logic [DATA_W-1:0]  sel_addr;

    logic               accept;
    logic               push, pull;
    logic [DATA_W-1:0]  res_addr;
    status_t            res_status;

    assign accept    = start && (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_MATCH;
            ST_MATCH: state_next = ST_PICK;
            ST_PICK:  state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != ST_IDLE);
        push        = 1'b0;
        pull        = 1'b0;
        res_addr    = '0;
        res_status  = STAT_IGNORED;
        count_next  = count_reg;
        offset_next = offset_reg;
        if (state_reg == ST_DONE)
        begin
            if (kind_reg == KIND_FREE)
            begin
                if (addr_reg == '0)
                begin
                    res_status = STAT_IGNORED;
                end
                else if (count_reg == CNT_W'(FREE_ENTRIES))
                begin
                    res_status = STAT_TABLE_FULL;
                end
                else
                begin
                    push       = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    res_status = STAT_REUSED;
                end
            end
            else if (size_reg == '0)
            begin
                res_status = STAT_IGNORED;
            end
            else if (found_reg)
            begin
                pull       = 1'b1;
                count_next = count_reg - CNT_W'(1);
                res_addr   = sel_addr;
                res_status = STAT_REUSED;
            end
            else if (fit_reg)
            begin
                offset_next = bump_end_reg;
                res_addr    = arena_addr_reg;
                res_status  = STAT_BUMPED;
            end
            else
            begin
                res_status = STAT_NO_SPACE;
            end
        end
    end

    // ---------------- request latch ----------------
    always_comb
    begin
        size_in = req_size;
        if ((req_size < DATA_W'(minb_reg)) && ((kind == KIND_FREE) || (req_size != '0)))
        begin
            size_in = DATA_W'(minb_reg);
        end
        amask_in = AMASK_W'((16'd1 << align_log2) - 16'd1);
    end

    // ---------------- bump path ----------------
    always_comb
    begin
        aligned_next = ({1'b0, offset_reg} + (DATA_W+1)'(amask_reg))
                       & ~((DATA_W+1)'(amask_reg));
        bump_sum     = {1'b0, aligned_reg} + (DATA_W+2)'(size_reg);
        arena_sum    = (SUM_W'(base_reg) + SUM_W'(aligned_reg)) & ADDR_MASK;
    end

    // ---------------- newest hit ----------------
    always_comb
    begin
        hit_next = match_vec & ((~match_vec) + FREE_ENTRIES'(1));
        sel_addr = '0;
        for (int i = 0; i < FREE_ENTRIES; i++)
        begin
            if (hit_reg[i])
            begin
                sel_addr = sel_addr | entries[i].addr;
            end
        end
        // a removal shifts every cell at or above the hit
        pull_sel = pull ? ~(hit_reg - FREE_ENTRIES'(1)) : '0;
    end

    assign ctl.push           = push;
    assign ctl.new_entry.addr = addr_reg;
    assign ctl.new_entry.size = size_reg;
    assign ctl.req_size       = size_reg;
    assign ctl.amask          = amask_reg;

    for (genvar i = 0; i < FREE_ENTRIES; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;

        if (i == 0)
        begin : g_head
            assign left_e = ctl.new_entry;
        end
        else
        begin : g_mid
            assign left_e = entries[i-1];
        end

        if (i == FREE_ENTRIES - 1)
        begin : g_tail
            assign right_e = entries[i];
        end
        else
        begin : g_body
            assign right_e = entries[i+1];
        end

        assign occupied[i] = (CNT_W'(i) < count_reg);

        ffa_cell u_cell
        (
            .clk         (clk),
            .ctl         (ctl),
            .pull_sel    (pull_sel[i]),
            .occupied    (occupied[i]),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (entries[i]),
            .match       (match_vec[i])
        );
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            base_reg   <= ARENA_BASE_RST;
            cap_reg    <= ARENA_CAP_RST;
            minb_reg   <= MIN_BLOCK_RST;
            count_reg  <= '0;
            offset_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
            done_reg   <= (state_reg == ST_DONE);
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ARENA_BASE: base_reg <= cfg_data;
                    CFG_ARENA_CAP:  cap_reg  <= cfg_data;
                    CFG_MIN_BLOCK:  minb_reg <= cfg_data[MINB_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            size_reg  <= size_in;
            amask_reg <= amask_in;
            addr_reg  <= block_addr;
        end
        if (state_reg == ST_MATCH)
        begin
            aligned_reg <= aligned_next;
        end
        if (state_reg == ST_PICK)
        begin
            hit_reg        <= hit_next;
            found_reg      <= |match_vec;
            fit_reg        <= (bump_sum <= (DATA_W+2)'(cap_reg));
            bump_end_reg   <= bump_sum[DATA_W-1:0];
            arena_addr_reg <= arena_sum[DATA_W-1:0];
        end
        if (state_reg == ST_DONE)
        begin
            result_addr_reg <= res_addr;
            status_reg      <= res_status;
        end
    end

    assign done        = done_reg;
    assign result_addr = result_addr_reg;
    assign status      = status_reg;

    // ---------------- checks ----------------
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FREE_ENTRIES))
        else $error("free count beyond table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_DONE))
        else $error("result word without a finished request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> ($onehot0(hit_reg) && (found_reg == (hit_reg != '0))))
        else $error("table pick is not a single entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(state_reg == ST_DONE))
        else $error("free count moved outside the update step");

endmodule

`default_nettype wire

// ===== rtl/ffa_cell.sv =====
`default_nettype none

module ffa_cell
    import ffa_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      pull_sel,
    input  logic      occupied,
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    output entry_t    entry,
    output logic      match
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   match_reg;
    logic   match_next;

    // push moves the stack down one cell, a pull closes the gap from above
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.push)
        begin
            entry_next = left_entry;
        end
        else if (pull_sel)
        begin
            entry_next = right_entry;
        end
    end

    always_comb
    begin
        match_next = occupied
                     && (entry_reg.size >= ctl.req_size)
                     && ((entry_reg.addr[AMASK_W-1:0] & ctl.amask) == '0);
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== test/first_fit_free_list_allocator_tb.sv =====
`timescale 1ns / 100ps

module first_fit_free_list_allocator_tb;
    import ffa_pkg::*;

    localparam int DEPTH        = FREE_ENTRIES_DEF;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE       = 6;
    localparam int MAX_REPORTS  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [DATA_W-1:0] addr;
        status_t           stat;
    } grant_t;

    // Tracks the free table, bump offset and registers; queues one grant per request.
    class alloc_checker;
        logic [DATA_W-1:0] ent_addr[DEPTH];
        logic [DATA_W-1:0] ent_size[DEPTH];
        int                fill;
        logic [63:0]       bump;
        logic [63:0]       base;
        logic [63:0]       cap;
        logic [63:0]       min_blk;
        grant_t            pending[$];
        int                errors;
        int                by_status[5];

        function void power_up();
            fill    = 0;
            bump    = '0;
            base    = ARENA_BASE_RST;
            cap     = ARENA_CAP_RST;
            min_blk = MIN_BLOCK_RST;
            errors  = 0;
            foreach (by_status[s])
                by_status[s] = 0;
        endfunction

        function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_ARENA_BASE: base = data;
                CFG_ARENA_CAP:  cap = data;
                CFG_MIN_BLOCK:  min_blk = data[MINB_W-1:0];
                default: ;
            endcase
        endfunction

        function grant_t take_request(logic k, logic [DATA_W-1:0] size_in,
                                      logic [ALIGN_W-1:0] align, logic [DATA_W-1:0] addr);
            logic [63:0] size;
            logic [63:0] amask;
            logic [63:0] aligned;
            logic [63:0] sum;
            grant_t      g;
            int          hit;
            int          i;
            size  = size_in;
            amask = (64'd1 << align) - 64'd1;
            if (size < min_blk && (k == KIND_FREE || size != 0))
                size = min_blk;
            g.addr = '0;
            g.stat = STAT_IGNORED;
            if (k == KIND_FREE)
            begin
                if (addr == '0)
                    g.stat = STAT_IGNORED;
                else if (fill >= DEPTH)
                    g.stat = STAT_TABLE_FULL;
                else
                begin
                    ent_addr[fill] = addr;
                    ent_size[fill] = size[DATA_W-1:0];
                    fill++;
                    g.stat = STAT_REUSED;
                end
            end
            else if (size != 0)
            begin
                // newest entry first; the first fit wins
                hit = -1;
                for (i = fill - 1; i >= 0 && hit < 0; i--)
                    if (ent_size[i] >= size && (ent_addr[i] & amask) == 0)
                        hit = i;
                if (hit >= 0)
                begin
                    g.addr = ent_addr[hit];
                    g.stat = STAT_REUSED;
                    for (i = hit; i < fill - 1; i++)
                    begin
                        ent_addr[i] = ent_addr[i + 1];
                        ent_size[i] = ent_size[i + 1];
                    end
                    fill--;
                end
                else
                begin
                    aligned = (bump + amask) & ~amask;
                    if (aligned + size > cap)
                        g.stat = STAT_NO_SPACE;
                    else
                    begin
                        bump   = aligned + size;
                        sum    = base + aligned;
                        g.addr = sum[DATA_W-1:0];
                        g.stat = STAT_BUMPED;
                    end
                end
            end
            pending.push_back(g);
            by_status[g.stat]++;
            return g;
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("ERROR at %0t: %s", $realtime, msg);
        endfunction

        function void check_reply(logic [DATA_W-1:0] addr, logic [2:0] stat);
            grant_t want;
            if (pending.size() == 0)
            begin
                note_error($sformatf("unexpected result addr %h status %0d", addr, stat));
                return;
            end
            want = pending.pop_front();
            if (addr !== want.addr)
                note_error($sformatf("result_addr %h, expected %h", addr, want.addr));
            if (stat !== want.stat)
                note_error($sformatf("status %0d, expected %0d", stat, want.stat));
        endfunction
    endclass

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic                 kind       = KIND_ALLOC;
    logic [DATA_W-1:0]    req_size   = '0;
    logic [ALIGN_W-1:0]   align_log2 = '0;
    logic [DATA_W-1:0]    block_addr = '0;
    logic                 cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [DATA_W-1:0]    cfg_data   = '0;
    logic                 busy;
    logic                 done;
    logic [DATA_W-1:0]    result_addr;
    logic [2:0]           status;
    logic                 cfg_ready;

    alloc_checker         sb;
    logic [DATA_W-1:0]    live_addr[$];
    logic [DATA_W-1:0]    live_size[$];
    int                   cycles   = 0;
    int                   settings = 1;
    int                   requests = 0;

    first_fit_free_list_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .req_size    (req_size),
        .align_log2  (align_log2),
        .block_addr  (block_addr),
        .done        (done),
        .result_addr (result_addr),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_reply(result_addr, status);

    // Leaves start high after acceptance so the next word can follow back to back.
    task automatic send_word(logic k, logic [DATA_W-1:0] size, logic [ALIGN_W-1:0] align,
                             logic [DATA_W-1:0] addr);
        grant_t g;
        start      <= 1'b1;
        kind       <= k;
        req_size   <= size;
        align_log2 <= align;
        block_addr <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        g = sb.take_request(k, size, align, addr);
        requests++;
        if (k == KIND_ALLOC && (g.stat == STAT_BUMPED || g.stat == STAT_REUSED))
        begin
            live_addr.push_back(g.addr);
            live_size.push_back(size);
            if (live_addr.size() > 64)
            begin
                void'(live_addr.pop_front());
                void'(live_size.pop_front());
            end
        end
    endtask

    task automatic hold_off(int n);
        if (n == 0)
            return;
        start <= 1'b0;
        repeat (n)
            @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    // cfg_valid stays high across consecutive writes; close_cfg drops it
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.load_reg(idx, data);
    endtask

    task automatic close_cfg();
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    function automatic logic [DATA_W-1:0] pick_size(int big_pct);
        int r;
        r = $urandom_range(99);
        if (r < big_pct)
            return $urandom;
        else if (r < big_pct + 5)
            return '0;
        else if (r < big_pct + 20)
            return $urandom_range(1, 16);
        return $urandom_range(1, 512);
    endfunction

    function automatic logic [ALIGN_W-1:0] pick_align();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return ALIGN_W'($urandom_range(0, 4));
        else if (r < 95)
            return ALIGN_W'($urandom_range(5, 12));
        return ALIGN_W'($urandom_range(13, 15));
    endfunction

    task automatic random_item(int free_pct, int big_pct);
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] addr;
        int                r;
        int                idx;
        size = pick_size(big_pct);
        addr = $urandom;
        if ($urandom_range(99) < free_pct)
        begin
            r = $urandom_range(99);
            if (r < 8)
                addr = '0;
            else if (r < 80 && live_addr.size() > 0)
            begin
                // give back a live block, usually with its own size
                idx  = $urandom_range(live_addr.size() - 1);
                addr = live_addr[idx];
                if ($urandom_range(3) != 0)
                    size = live_size[idx];
                live_addr.delete(idx);
                live_size.delete(idx);
            end
            send_word(KIND_FREE, size, ALIGN_W'($urandom_range(0, 15)), addr);
        end
        else
            send_word(KIND_ALLOC, size, pick_align(), addr);
    endtask

    task automatic run_phase(int n, int free_pct, int big_pct);
        int sent;
        int burst;
        int b;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 24);
            for (b = 0; b < burst && sent < n; b++)
            begin
                random_item(free_pct, big_pct);
                sent++;
            end
            if ($urandom_range(11) == 0)
                drain_results();
            else if ($urandom_range(3) != 0)
                hold_off($urandom_range(1, 8));
        end
        drain_results();
    endtask

    initial
    begin
        int k;
        sb = new;
        sb.power_up();
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with reset register values
        send_word(KIND_ALLOC, 32'd0, 4'd0, 32'hFFFF_FFFF);
        send_word(KIND_FREE, 32'd5, 4'd15, 32'd0);
        send_word(KIND_ALLOC, 32'd1, 4'd0, 32'd0);
        send_word(KIND_ALLOC, 32'hFFFF_FFFF, 4'd0, 32'd0);
        send_word(KIND_ALLOC, 32'd100, 4'd12, 32'd0);
        send_word(KIND_ALLOC, 32'd16, 4'd15, 32'd0);
        send_word(KIND_ALLOC, 32'd32, 4'd15, 32'd0);
        send_word(KIND_FREE, 32'd0, 4'd0, 32'hFFFF_FFFF);
        send_word(KIND_FREE, 32'hFFFF_FFFF, 4'd0, 32'h0000_1000);
        for (k = 1; k <= DEPTH - 2; k++)
            send_word(KIND_FREE, k * 8, 4'd0, 32'h8000_0000 + k * 32'h40);
        // one word past the table depth gets dropped
        send_word(KIND_FREE, 32'd64, 4'd0, 32'h0000_2000);
        send_word(KIND_ALLOC, 32'd64, 4'd8, 32'd0);
        send_word(KIND_ALLOC, 32'h8000_0000, 4'd0, 32'd0);
        send_word(KIND_ALLOC, 32'd8, 4'd0, 32'd0);
        drain_results();

        run_phase(200, 45, 3);

        cfg_write(CFG_ARENA_BASE, 32'hFFFF_F000);
        cfg_write(CFG_ARENA_CAP, 32'hFFFF_FFFF);
        cfg_write(CFG_MIN_BLOCK, 32'd1);
        close_cfg();
        run_phase(250, 40, 8);

        cfg_write(CFG_ARENA_BASE, $urandom);
        cfg_write(CFG_ARENA_CAP, 32'd256);
        cfg_write(CFG_MIN_BLOCK, 32'd0);
        close_cfg();
        run_phase(200, 50, 3);

        cfg_write(CFG_ARENA_CAP, 32'd0);
        cfg_write(CFG_MIN_BLOCK, 32'd511);
        cfg_write(CFG_UNUSED, $urandom);
        close_cfg();
        run_phase(150, 50, 3);

        cfg_write(CFG_ARENA_BASE, 32'd0);
        cfg_write(CFG_ARENA_CAP, 32'hFFFF_FFFF);
        cfg_write(CFG_MIN_BLOCK, 32'd256);
        close_cfg();
        run_phase(200, 50, 2);

        cfg_write(CFG_ARENA_BASE, $urandom);
        cfg_write(CFG_MIN_BLOCK, $urandom_range(1, 256));
        close_cfg();
        run_phase(300, 62, 2);

        cfg_write(CFG_MIN_BLOCK, 32'd16);
        close_cfg();
        run_phase(300, 30, 1);

        $display("%0d requests over %0d register settings", requests, settings);
        $display("reused/freed %0d, bumped %0d, ignored %0d, out of space %0d, table full %0d",
                 sb.by_status[STAT_REUSED], sb.by_status[STAT_BUMPED],
                 sb.by_status[STAT_IGNORED], sb.by_status[STAT_NO_SPACE],
                 sb.by_status[STAT_TABLE_FULL]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
